// ===== src/mpsp_pkg.sv =====
`default_nettype none

package mpsp_pkg;

    localparam int MAX_PAGES  = 16;
    localparam int PAGE_IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int OPEN_W     = $clog2(MAX_PAGES + 1);
    localparam int SIZE_W     = 13;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

    localparam logic       ACT_PACK  = 1'b0;
    localparam logic       ACT_CLEAR = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;

    typedef struct packed {
        logic        action;
        logic [11:0] rect_width;
        logic [11:0] rect_height;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  page_index;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
    } res_t;

    typedef struct packed {
        logic [SIZE_W-1:0] free_x;
        logic [SIZE_W-1:0] top_y;
        logic [SIZE_W-1:0] tallest;
    } page_t;

    function automatic logic [3:0] to_page_field(input logic [PAGE_IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[3:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/multi_page_shelf_packer_core.sv =====
`default_nettype none

// Shelf packer for rectangles in square atlas pages.
// Command channel: a word on req is taken at a clock edge with start high and
// busy low. req.action selects pack (padded by one pixel each way) or clear.
// Result channel: done is high for exactly one cycle with the word on result;
// the receiver must take it then, it cannot stall the block.
// Configuration: cfg_data is the page size, written when cfg_valid is high;
// cfg_ready is always high. Write it only while the block is idle.
// Flow: a clear, or a pack with no page open, gives its result in the cycle
// after acceptance. Otherwise the page table memory is read one page per
// cycle from page 0 up: a pack lands on the first open page that fits it, and
// one that fits none opens a new page or, with all pages open, reports full.
// busy stays high until the result is written, so the next word may be taken
// in the cycle that done is high.
// The per-page table lies in a single-port-read memory with a registered
// read; its rate sets the one-page-per-cycle scan.
// Reset clears the page count and sets the page size to 4096; the memory is
// not cleared, since only opened pages are ever read.

module multi_page_shelf_packer_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire mpsp_pkg::req_t req,
    output logic               done,
    output mpsp_pkg::res_t     result,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [12:0]   cfg_data
);
    import mpsp_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                  state_reg, state_next;
    logic [OPEN_W-1:0]     open_pages_reg, open_pages_next;
    logic [PAGE_IDX_W-1:0] idx_reg, idx_next;
    logic [SIZE_W-1:0]     pw_reg, pw_next;
    logic [SIZE_W-1:0]     ph_reg, ph_next;
    logic [SIZE_W-1:0]     page_size_reg;
    logic                  done_reg, done_next;
    res_t                  result_reg, result_next;

    page_t                 page_mem [MAX_PAGES];
    page_t                 rd_data_reg;
    logic                  mem_we;
    logic [PAGE_IDX_W-1:0] mem_waddr;
    logic [PAGE_IDX_W-1:0] mem_raddr;
    page_t                 mem_wdata;

    logic                  accept;
    logic [SIZE_W-1:0]     cur_pw, cur_ph;
    logic [OPEN_W-1:0]     next_idx;
    logic                  last_page;
    logic                  atlas_full;
    logic                  too_large;
    logic                  fit_row, fit_new;
    logic [SIZE_W:0]       row_end_x, row_end_y, next_y;
    logic [SIZE_W+1:0]     new_end_y;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    assign cur_pw = (state_reg == S_IDLE) ? (13'(req.rect_width) + 13'd1) : pw_reg;
    assign cur_ph = (state_reg == S_IDLE) ? (13'(req.rect_height) + 13'd1) : ph_reg;

    assign next_idx   = OPEN_W'(idx_reg) + OPEN_W'(1);
    assign last_page  = (next_idx >= open_pages_reg);
    assign atlas_full = (open_pages_reg == OPEN_W'(MAX_PAGES));
    assign too_large  = (cur_pw > page_size_reg) || (cur_ph > page_size_reg);

    assign row_end_x = 14'(rd_data_reg.free_x) + 14'(cur_pw);
    assign row_end_y = 14'(rd_data_reg.top_y) + 14'(cur_ph);
    assign next_y    = 14'(rd_data_reg.top_y) + 14'(rd_data_reg.tallest);
    assign new_end_y = 15'(next_y) + 15'(cur_ph);
    assign fit_row   = (row_end_x <= 14'(page_size_reg)) && (row_end_y <= 14'(page_size_reg));
    assign fit_new   = (cur_pw <= page_size_reg) && (new_end_y <= 15'(page_size_reg));

    always_comb
    begin
        state_next      = state_reg;
        open_pages_next = open_pages_reg;
        idx_next        = idx_reg;
        pw_next         = pw_reg;
        ph_next         = ph_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        mem_we          = 1'b0;
        mem_waddr       = open_pages_reg[PAGE_IDX_W-1:0];
        mem_wdata       = '0;
        mem_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pw_next  = cur_pw;
                    ph_next  = cur_ph;
                    idx_next = '0;
                    if (req.action == ACT_CLEAR)
                    begin
                        open_pages_next = '0;
                        done_next       = 1'b1;
                        result_next     = '{ST_OK, 4'd0, 12'd0, 12'd0};
                    end
                    else if (open_pages_reg == '0)
                    begin
                        done_next = 1'b1;
                        mem_we    = 1'b1;
                        open_pages_next = open_pages_reg + OPEN_W'(1);
                        if (too_large)
                        begin
                            mem_wdata   = '0;
                            result_next = '{ST_TOO_LARGE, 4'd0, 12'd0, 12'd0};
                        end
                        else
                        begin
                            mem_wdata   = '{cur_pw, 13'd0, cur_ph};
                            result_next = '{ST_OK,
                                            to_page_field(open_pages_reg[PAGE_IDX_W-1:0]),
                                            12'd0, 12'd0};
                        end
                    end
                    else
                    begin
                        mem_raddr  = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                mem_raddr = next_idx[PAGE_IDX_W-1:0];
                if (fit_row)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wdata = '{row_end_x[SIZE_W-1:0], rd_data_reg.top_y,
                                  (cur_ph > rd_data_reg.tallest) ? cur_ph
                                                                 : rd_data_reg.tallest};
                    done_next   = 1'b1;
                    result_next = '{ST_OK, to_page_field(idx_reg),
                                    rd_data_reg.free_x[11:0], rd_data_reg.top_y[11:0]};
                    state_next  = S_IDLE;
                end
                else if (fit_new)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wdata = '{cur_pw, next_y[SIZE_W-1:0], cur_ph};
                    done_next   = 1'b1;
                    result_next = '{ST_OK, to_page_field(idx_reg), 12'd0, next_y[11:0]};
                    state_next  = S_IDLE;
                end
                else if (!last_page)
                begin
                    idx_next = next_idx[PAGE_IDX_W-1:0];
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (atlas_full)
                    begin
                        result_next = '{ST_FULL, 4'd0, 12'd0, 12'd0};
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        open_pages_next = open_pages_reg + OPEN_W'(1);
                        if (too_large)
                        begin
                            mem_wdata   = '0;
                            result_next = '{ST_TOO_LARGE, 4'd0, 12'd0, 12'd0};
                        end
                        else
                        begin
                            mem_wdata   = '{cur_pw, 13'd0, cur_ph};
                            result_next = '{ST_OK,
                                            to_page_field(open_pages_reg[PAGE_IDX_W-1:0]),
                                            12'd0, 12'd0};
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= page_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            open_pages_reg <= '0;
            idx_reg        <= '0;
            done_reg       <= 1'b0;
            page_size_reg  <= SIZE_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            open_pages_reg <= open_pages_next;
            idx_reg        <= idx_next;
            done_reg       <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                page_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pw_reg     <= pw_next;
        ph_reg     <= ph_next;
        result_reg <= result_next;
    end

    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_pages_reg <= OPEN_W'(MAX_PAGES))
        else $error("page count above limit");

    a_open_step: assert property (@(posedge clk) disable iff (!rst_n)
        (open_pages_reg != '0) && ($past(open_pages_reg) != open_pages_reg)
        |-> (open_pages_reg == $past(open_pages_reg) + OPEN_W'(1)))
        else $error("page count moved by more than one");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(accept || (state_reg == S_SCAN)))
        else $error("result without a request in flight");

    a_write_cause: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (accept || (state_reg == S_SCAN)))
        else $error("page table written while idle");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (result_reg.status == ST_OK || result_reg.status == ST_FULL
                      || result_reg.status == ST_TOO_LARGE))
        else $error("illegal status code");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (OPEN_W'(idx_reg) < open_pages_reg))
        else $error("scan beyond open pages");

endmodule

`default_nettype wire

// ===== tb/sv/shelf_packer_checker.sv =====
module shelf_packer_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  mpsp_pkg::req_t              req,
    input  logic                        done,
    input  mpsp_pkg::res_t              result,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [mpsp_pkg::SIZE_W-1:0] cfg_data,
    output int                          pending,
    output int                          mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import mpsp_pkg::*;

    logic [SIZE_W-1:0] page_px;
    logic [OPEN_W-1:0] pages_open;
    logic [SIZE_W-1:0] shelf_x [MAX_PAGES];
    logic [SIZE_W-1:0] shelf_y [MAX_PAGES];
    logic [SIZE_W-1:0] shelf_h [MAX_PAGES];
    res_t              placements_due [$];

    initial
    begin
        mismatches = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
    endtask

    function automatic res_t shelf_place(input req_t r);
        res_t        o;
        int unsigned pw;
        int unsigned ph;
        int unsigned cx;
        int unsigned ty;
        int unsigned below;
        int unsigned slot;
        o = '0;
        o.status = ST_OK;
        if (r.action == ACT_CLEAR)
        begin
            pages_open = '0;
            return o;
        end
        pw = 32'(r.rect_width) + 32'd1;
        ph = 32'(r.rect_height) + 32'd1;
        for (int p = 0; p < int'(pages_open); p++)
        begin
            cx = 32'(shelf_x[p]);
            ty = 32'(shelf_y[p]);
            if (cx + pw <= 32'(page_px) && ty + ph <= 32'(page_px))
            begin
                shelf_x[p] = SIZE_W'(cx + pw);
                if (ph > 32'(shelf_h[p]))
                    shelf_h[p] = SIZE_W'(ph);
                o.page_index = 4'(p);
                o.pos_x = 12'(cx);
                o.pos_y = 12'(ty);
                return o;
            end
            below = ty + 32'(shelf_h[p]);
            if (pw <= 32'(page_px) && below + ph <= 32'(page_px))
            begin
                shelf_x[p] = SIZE_W'(pw);
                shelf_y[p] = SIZE_W'(below);
                shelf_h[p] = SIZE_W'(ph);
                o.page_index = 4'(p);
                o.pos_y = 12'(below);
                return o;
            end
        end
        if (int'(pages_open) >= MAX_PAGES)
        begin
            o.status = ST_FULL;
            return o;
        end
        slot = 32'(pages_open);
        pages_open = pages_open + 1'b1;
        shelf_y[slot] = '0;
        if (pw > 32'(page_px) || ph > 32'(page_px))
        begin
            shelf_x[slot] = '0;
            shelf_h[slot] = '0;
            o.status = ST_TOO_LARGE;
            return o;
        end
        shelf_x[slot] = SIZE_W'(pw);
        shelf_h[slot] = SIZE_W'(ph);
        o.page_index = 4'(slot);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            placements_due.delete();
            page_px = SIZE_RESET;
            pages_open = '0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (placements_due.size() == 0)
                    report_mismatch("unexpected result word, status", int'(result.status), 0);
                else
                begin
                    want = placements_due.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", int'(result.status), int'(want.status));
                    if (result.page_index !== want.page_index)
                        report_mismatch("page_index", int'(result.page_index),
                                        int'(want.page_index));
                    if (result.pos_x !== want.pos_x)
                        report_mismatch("pos_x", int'(result.pos_x), int'(want.pos_x));
                    if (result.pos_y !== want.pos_y)
                        report_mismatch("pos_y", int'(result.pos_y), int'(want.pos_y));
                end
            end
            if (start && !busy)
                placements_due = {placements_due, shelf_place(req)};
            if (cfg_valid && cfg_ready)
                page_px = cfg_data;
            pending <= placements_due.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpsp_pkg::*;

    localparam int QUIET_LIMIT     = 1000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 127;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    req_t              req;
    logic              done;
    res_t              result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data;
    int                pending;
    int                mismatches;
    int                quiet = 0;

    int unsigned       burst_left = 0;
    bit                steady = 1'b0;
    logic [SIZE_W-1:0] size_plan [PHASES];

    always #6 clk = ~clk;

    multi_page_shelf_packer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    shelf_packer_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic req_t mk(input logic act, input logic [11:0] w, input logic [11:0] h);
        req_t r;
        r.action = act;
        r.rect_width = w;
        r.rect_height = h;
        return r;
    endfunction

    function automatic logic [11:0] clip(input int unsigned v);
        return (v > 32'd4095) ? 12'd4095 : 12'(v);
    endfunction

    function automatic req_t random_item(input int unsigned sz);
        req_t        r;
        int unsigned pick;
        int unsigned k;
        r = mk(ACT_PACK, 12'($urandom), 12'($urandom));
        pick = $urandom_range(0, 29);
        k = $urandom_range(0, 2);
        if (pick == 0)
            r.action = ACT_CLEAR;
        else if (pick < 18)
        begin
            r.rect_width = 12'($urandom_range(0, clip(sz / 8)));
            r.rect_height = 12'($urandom_range(0, clip(sz / 8)));
        end
        else if (pick < 24)
        begin
            r.rect_width = 12'($urandom_range(0, clip(sz)));
            r.rect_height = 12'($urandom_range(0, clip(sz)));
        end
        else if (pick < 27)
        begin
            r.rect_width = clip((sz > k) ? sz - k : 0);
            r.rect_height = 12'($urandom_range(0, clip(sz / 4)));
            if ($urandom_range(0, 1) == 0)
                {r.rect_width, r.rect_height} = {r.rect_height, r.rect_width};
        end
        return r;
    endfunction

    task automatic issue(input req_t w);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap != 0)
            begin
                start <= 1'b0;
                req <= mk(1'($urandom), 12'($urandom), 12'($urandom));
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        req <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_page_size(input logic [SIZE_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        req <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        size_plan[0] = 13'd1;
        size_plan[1] = 13'd0;
        size_plan[2] = 13'd8191;
        size_plan[3] = 13'd4096;
        size_plan[4] = 13'd2;
        size_plan[5] = 13'd4095;
        size_plan[6] = 13'd64;
        for (int i = 7; i < PHASES; i++)
            size_plan[i] = 13'($urandom_range(3, 4096));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(mk(ACT_PACK, 12'd0, 12'd0));
        issue(mk(ACT_PACK, 12'd4095, 12'd0));
        issue(mk(ACT_PACK, 12'd4095, 12'd4095));
        issue(mk(ACT_PACK, 12'd0, 12'd4095));
        issue(mk(ACT_PACK, 12'hAAA, 12'h555));
        issue(mk(ACT_PACK, 12'h555, 12'hAAA));
        issue(mk(ACT_CLEAR, 12'hFFF, 12'hFFF));
        repeat (MAX_PAGES) issue(mk(ACT_PACK, 12'd4095, 12'd4095));
        issue(mk(ACT_PACK, 12'd0, 12'd0));
        issue(mk(ACT_CLEAR, 12'd0, 12'd0));

        for (int i = 0; i < PHASES; i++)
        begin
            write_page_size(size_plan[i]);
            steady = ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_PHASE) issue(random_item(32'(size_plan[i])));
        end

        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== multi_page_shelf_packer_core.f =====
src/mpsp_pkg.sv
src/multi_page_shelf_packer_core.sv
tb/sv/shelf_packer_checker.sv
tb/sv/tb.sv
